### design/lpcp_pkg.sv
`timescale 1ns / 1ps

package lpcp_pkg;

	// Field and register widths
	localparam int POS_W  = 18;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 3;
	localparam int OUT_W  = 20;
	localparam int FOC_W  = 16;
	localparam int K_W    = 18;

	// Camera-frame coordinates at 2^-15 mm: magnitude stays below 2^33
	localparam int CAM_W  = 34;
	localparam int MAG_W  = CAM_W - 1;

	// Normalized coordinates: 20 quotient bits, 16 of them fractional
	localparam int QBITS     = 20;
	localparam int NORM_FRAC = 16;
	localparam int LO_W      = QBITS - NORM_FRAC;
	localparam int NORM_W    = QBITS + 1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_FOCAL = 3'd0,
		CFG_CCOL  = 3'd1,
		CFG_CROW  = 3'd2,
		CFG_K1    = 3'd3,
		CFG_K2    = 3'd4
	} cfg_idx_t;

	// Register reset values
	localparam logic [FOC_W-1:0]      FOCAL_RST = 16'd40981;
	localparam logic [FOC_W-1:0]      CCOL_RST  = 16'd18883;
	localparam logic [FOC_W-1:0]      CROW_RST  = 16'd16574;
	localparam logic signed [K_W-1:0] K1_RST    = -18'sd9660;
	localparam logic signed [K_W-1:0] K2_RST    = 18'sd7537;

	// Extrinsic rotation, Q1.15, row major
	localparam logic signed [15:0] ROT_Q15 [9] = '{
		16'sd466,   -16'sd32754, -16'sd855,
		-16'sd717,  16'sd845,    -16'sd32749,
		16'sd32757, 16'sd484,    -16'sd705
	};

	// Extrinsic translation, mm at 2^-15
	localparam logic signed [22:0] TRANS_Q15 [3] = '{
		23'sd219996, 23'sd2132391, -23'sd464896
	};

	// Flags that ride along with the divider
	typedef struct packed {
		logic pos;
		logic sx;
		logic sy;
		logic ovx;
		logic ovy;
	} side_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic             qb;
	} div_step_t;

	// One restoring division step: shift in a numerator bit, subtract if it fits
	function automatic div_step_t div_step(input logic [MAG_W-1:0] rem, input logic nb,
			input logic [MAG_W-1:0] dv);
		logic [MAG_W:0] trial;
		div_step_t      r;
		trial = {rem, nb};
		if (trial >= {1'b0, dv}) begin
			r.rem = MAG_W'(trial - {1'b0, dv});
			r.qb  = 1'b1;
		end else begin
			r.rem = trial[MAG_W-1:0];
			r.qb  = 1'b0;
		end
		return r;
	endfunction

endpackage

### design/lidar_point_camera_projection.sv
`timescale 1ns / 1ps

// Lidar point to camera pixel projection. Each request carries one lidar point
// (x, y, z in mm); the block applies the fixed extrinsic transform, divides by
// camera depth, applies radial distortion 1 + k1*r^2 + k2*r^4 and returns the
// image row and column in 1/16 pixel. One point is taken every cycle unless
// the output stalls; transform stages feed the 20-stage divider (one quotient
// bit per stage), then distortion and scaling. A stall on the output holds the
// whole pipeline. Depth of zero or less gives row 0, column 0, valid_res 0;
// a normalized coordinate of 16.0 or more, or a pixel outside the 20-bit
// signed range, is saturated and clears valid_res. Configuration registers
// (focal length, principal point, k1, k2) must be written only while idle.
module lidar_point_camera_projection import lpcp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [POS_W-1:0]  pos_x_mm,
	input  logic signed [POS_W-1:0]  pos_y_mm,
	input  logic signed [POS_W-1:0]  pos_z_mm,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  pixel_row_q4,
	output logic signed [OUT_W-1:0]  pixel_col_q4,
	output logic                     valid_res
);

	localparam int SQ_W   = 2 * QBITS;
	localparam int R2_W   = SQ_W + 1 - NORM_FRAC;
	localparam int R2SQ_W = 2 * R2_W;
	localparam int R4_W   = R2SQ_W - NORM_FRAC;
	localparam int K1R_W  = K_W + R2_W + 1;
	localparam int K2R_W  = K_W + R4_W + 1;
	localparam int SUM_W  = K2R_W + 1;
	localparam int DIST_W = SUM_W - NORM_FRAC + 1;
	localparam int XD_W   = NORM_W + DIST_W;
	localparam int XDS_W  = XD_W - NORM_FRAC;
	localparam int FX_W   = FOC_W + 1 + XDS_W;
	localparam int PIX_W  = FX_W - NORM_FRAC + 1;

	localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(signed'(OUT_W'(2 ** (OUT_W-1) - 1)));
	localparam logic signed [PIX_W-1:0] PIX_MIN = -PIX_W'(2 ** (OUT_W-1));

	// Configuration registers
	logic [FOC_W-1:0]      focal_q, ccol_q, crow_q;
	logic signed [K_W-1:0] k1_q, k2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RST;
			ccol_q  <= CCOL_RST;
			crow_q  <= CROW_RST;
			k1_q    <= K1_RST;
			k2_q    <= K2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FOCAL: focal_q <= cfg_data[FOC_W-1:0];
				CFG_CCOL:  ccol_q  <= cfg_data[FOC_W-1:0];
				CFG_CROW:  crow_q  <= cfg_data[FOC_W-1:0];
				CFG_K1:    k1_q    <= signed'(cfg_data[K_W-1:0]);
				CFG_K2:    k2_q    <= signed'(cfg_data[K_W-1:0]);
				default:   ;
			endcase
		end
	end

	// Whole pipeline advances unless the output holds an untaken request
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Pipeline valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= div_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// s1: rotation products
	logic signed [POS_W-1:0] pin [3];
	logic signed [CAM_W-1:0] prod_s1 [9];

	assign pin[0] = pos_x_mm;
	assign pin[1] = pos_y_mm;
	assign pin[2] = pos_z_mm;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) prod_s1[i] <= ROT_Q15[i] * pin[i % 3];
		end
	end

	// s2: camera-frame point (sums fit in CAM_W; intermediate wrap is harmless)
	logic signed [CAM_W-1:0] cam_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cam_s2[i] <= prod_s1[3*i] + prod_s1[3*i+1] + prod_s1[3*i+2]
					+ CAM_W'(TRANS_Q15[i]);
			end
		end
	end

	// s3: magnitudes, signs, depth check and quotient overflow (|c| >= 16*zc)
	logic [MAG_W-1:0] absx_s3, absy_s3, zc_s3;
	side_t            side_s3;
	logic [MAG_W-1:0] absx, absy;

	always_comb begin
		absx = cam_s2[0][CAM_W-1] ? MAG_W'(-cam_s2[0]) : cam_s2[0][MAG_W-1:0];
		absy = cam_s2[1][CAM_W-1] ? MAG_W'(-cam_s2[1]) : cam_s2[1][MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			absx_s3     <= absx;
			absy_s3     <= absy;
			zc_s3       <= cam_s2[2][MAG_W-1:0];
			side_s3.pos <= (cam_s2[2] > 0);
			side_s3.sx  <= cam_s2[0][CAM_W-1];
			side_s3.sy  <= cam_s2[1][CAM_W-1];
			side_s3.ovx <= ({{LO_W{1'b0}}, absx} >= {cam_s2[2][MAG_W-1:0], {LO_W{1'b0}}});
			side_s3.ovy <= ({{LO_W{1'b0}}, absy} >= {cam_s2[2][MAG_W-1:0], {LO_W{1'b0}}});
		end
	end

	// Divider stages
	side_t            div_side;
	logic [QBITS-1:0] div_qx, div_qy;

	lpcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_side  (side_s3),
		.divisor  (zc_s3),
		.num_x    (absx_s3),
		.num_y    (absy_s3),
		.out_vld  (div_vld),
		.out_side (div_side),
		.quo_x    (div_qx),
		.quo_y    (div_qy)
	);

	// s4: clamp and restore sign of normalized coordinates
	logic signed [NORM_W-1:0] xo_s4, yo_s4;
	logic                     ok_s4, pos_s4;
	logic [QBITS-1:0]         magx, magy;

	always_comb begin
		magx = div_side.ovx ? '1 : div_qx;
		magy = div_side.ovy ? '1 : div_qy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xo_s4  <= div_side.sx ? -signed'({1'b0, magx}) : signed'({1'b0, magx});
			yo_s4  <= div_side.sy ? -signed'({1'b0, magy}) : signed'({1'b0, magy});
			ok_s4  <= !(div_side.ovx || div_side.ovy);
			pos_s4 <= div_side.pos;
		end
	end

	// s5: squares
	logic [SQ_W-1:0]          xsq_s5, ysq_s5;
	logic signed [NORM_W-1:0] xo_s5, yo_s5;
	logic                     ok_s5, pos_s5;
	logic signed [2*NORM_W-1:0] xsq_full, ysq_full;

	always_comb begin
		xsq_full = xo_s4 * xo_s4;
		ysq_full = yo_s4 * yo_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s5 <= xsq_full[SQ_W-1:0];
			ysq_s5 <= ysq_full[SQ_W-1:0];
			xo_s5  <= xo_s4;
			yo_s5  <= yo_s4;
			ok_s5  <= ok_s4;
			pos_s5 <= pos_s4;
		end
	end

	// s6: r2
	logic [R2_W-1:0]          r2_s6;
	logic signed [NORM_W-1:0] xo_s6, yo_s6;
	logic                     ok_s6, pos_s6;
	logic [SQ_W:0]            rsum;

	assign rsum = {1'b0, xsq_s5} + {1'b0, ysq_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s6  <= rsum[SQ_W:NORM_FRAC];
			xo_s6  <= xo_s5;
			yo_s6  <= yo_s5;
			ok_s6  <= ok_s5;
			pos_s6 <= pos_s5;
		end
	end

	// s7: r2 squared and k1 term
	logic [R2SQ_W-1:0]        r2sq_s7;
	logic signed [K1R_W-1:0]  k1r_s7;
	logic signed [NORM_W-1:0] xo_s7, yo_s7;
	logic                     ok_s7, pos_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			r2sq_s7 <= r2_s6 * r2_s6;
			k1r_s7  <= k1_q * signed'({1'b0, r2_s6});
			xo_s7   <= xo_s6;
			yo_s7   <= yo_s6;
			ok_s7   <= ok_s6;
			pos_s7  <= pos_s6;
		end
	end

	// s8: k2 term on r4
	logic signed [K2R_W-1:0]  k2r_s8;
	logic signed [K1R_W-1:0]  k1r_s8;
	logic signed [NORM_W-1:0] xo_s8, yo_s8;
	logic                     ok_s8, pos_s8;
	logic [R4_W-1:0]          r4;

	assign r4 = r2sq_s7[R2SQ_W-1:NORM_FRAC];

	always_ff @(posedge clk) begin
		if (en) begin
			k2r_s8 <= k2_q * signed'({1'b0, r4});
			k1r_s8 <= k1r_s7;
			xo_s8  <= xo_s7;
			yo_s8  <= yo_s7;
			ok_s8  <= ok_s7;
			pos_s8 <= pos_s7;
		end
	end

	// s9: distortion factor D = 1 + floor((k1*r2 + k2*r4) / 2^16)
	logic signed [DIST_W-1:0] dist_s9;
	logic signed [NORM_W-1:0] xo_s9, yo_s9;
	logic                     ok_s9, pos_s9;
	logic signed [SUM_W-1:0]  dsum;

	assign dsum = SUM_W'(k1r_s8) + SUM_W'(k2r_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s9 <= DIST_W'(signed'(dsum[SUM_W-1:NORM_FRAC]))
				+ DIST_W'(2 ** NORM_FRAC);
			xo_s9   <= xo_s8;
			yo_s9   <= yo_s8;
			ok_s9   <= ok_s8;
			pos_s9  <= pos_s8;
		end
	end

	// s10: distorted coordinates
	logic signed [XD_W-1:0] xd_s10, yd_s10;
	logic                   ok_s10, pos_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			xd_s10  <= xo_s9 * dist_s9;
			yd_s10  <= yo_s9 * dist_s9;
			ok_s10  <= ok_s9;
			pos_s10 <= pos_s9;
		end
	end

	// s11: focal scaling
	logic signed [FX_W-1:0]  fx_s11, fy_s11;
	logic                    ok_s11, pos_s11;
	logic signed [XDS_W-1:0] xds, yds;
	logic signed [FOC_W:0]   fsig;

	always_comb begin
		xds  = xd_s10[XD_W-1:NORM_FRAC];
		yds  = yd_s10[XD_W-1:NORM_FRAC];
		fsig = signed'({1'b0, focal_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s11  <= fsig * xds;
			fy_s11  <= fsig * yds;
			ok_s11  <= ok_s10;
			pos_s11 <= pos_s10;
		end
	end

	// s12: principal point offset, saturation, output register
	logic signed [PIX_W-1:0] colw, roww;
	logic signed [OUT_W-1:0] col_s12, row_s12;
	logic                    res_s12;
	logic                    col_hi, col_lo, row_hi, row_lo;

	always_comb begin
		colw   = PIX_W'(signed'(fx_s11[FX_W-1:NORM_FRAC]))
			+ signed'(PIX_W'({1'b0, ccol_q}));
		roww   = PIX_W'(signed'(fy_s11[FX_W-1:NORM_FRAC]))
			+ signed'(PIX_W'({1'b0, crow_q}));
		col_hi = colw > PIX_MAX;
		col_lo = colw < PIX_MIN;
		row_hi = roww > PIX_MAX;
		row_lo = roww < PIX_MIN;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (!pos_s11) begin
				col_s12 <= '0;
				row_s12 <= '0;
			end else begin
				col_s12 <= col_hi ? OUT_W'(PIX_MAX) : (col_lo ? OUT_W'(PIX_MIN) : colw[OUT_W-1:0]);
				row_s12 <= row_hi ? OUT_W'(PIX_MAX) : (row_lo ? OUT_W'(PIX_MIN) : roww[OUT_W-1:0]);
			end
			res_s12 <= pos_s11 && ok_s11 && !(col_hi || col_lo || row_hi || row_lo);
		end
	end

	assign out_valid    = vld_s12;
	assign pixel_row_q4 = row_s12;
	assign pixel_col_q4 = col_s12;
	assign valid_res    = res_s12;

endmodule

### design/lpcp_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, x and y lanes
// sharing the depth divisor. Quotient = floor(num * 2^16 / divisor), low 20 bits.
module lpcp_div import lpcp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  side_t            in_side,
	input  logic [MAG_W-1:0] divisor,
	input  logic [MAG_W-1:0] num_x,
	input  logic [MAG_W-1:0] num_y,
	output logic             out_vld,
	output side_t            out_side,
	output logic [QBITS-1:0] quo_x,
	output logic [QBITS-1:0] quo_y
);

	// Stage registers
	logic [MAG_W-1:0] rem_x_s [QBITS-1];
	logic [MAG_W-1:0] rem_y_s [QBITS-1];
	logic [LO_W-1:0]  nlo_x_s [QBITS-1];
	logic [LO_W-1:0]  nlo_y_s [QBITS-1];
	logic [MAG_W-1:0] dv_s    [QBITS-1];
	logic [QBITS-1:0] quo_x_s [QBITS];
	logic [QBITS-1:0] quo_y_s [QBITS];
	side_t            side_s  [QBITS];
	logic             vld_s   [QBITS];

	// Stage inputs and step results
	logic [MAG_W-1:0] pr_x [QBITS];
	logic [MAG_W-1:0] pr_y [QBITS];
	logic [LO_W-1:0]  lo_x [QBITS];
	logic [LO_W-1:0]  lo_y [QBITS];
	logic [MAG_W-1:0] dv   [QBITS];
	logic [QBITS-1:0] qx   [QBITS];
	logic [QBITS-1:0] qy   [QBITS];
	div_step_t        st_x [QBITS];
	div_step_t        st_y [QBITS];

	// Partial remainder starts at num >> 4; the low 4 bits are shifted in first
	always_comb begin
		pr_x[0] = MAG_W'(num_x >> LO_W);
		pr_y[0] = MAG_W'(num_y >> LO_W);
		lo_x[0] = num_x[LO_W-1:0];
		lo_y[0] = num_y[LO_W-1:0];
		dv[0]   = divisor;
		qx[0]   = '0;
		qy[0]   = '0;
		for (int k = 1; k < QBITS; k++) begin
			pr_x[k] = rem_x_s[k-1];
			pr_y[k] = rem_y_s[k-1];
			lo_x[k] = nlo_x_s[k-1];
			lo_y[k] = nlo_y_s[k-1];
			dv[k]   = dv_s[k-1];
			qx[k]   = quo_x_s[k-1];
			qy[k]   = quo_y_s[k-1];
		end
		for (int k = 0; k < QBITS; k++) begin
			st_x[k] = div_step(pr_x[k], lo_x[k][LO_W-1], dv[k]);
			st_y[k] = div_step(pr_y[k], lo_y[k][LO_W-1], dv[k]);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QBITS; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < QBITS; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 1; k < QBITS; k++) side_s[k] <= side_s[k-1];
			for (int k = 0; k < QBITS; k++) begin
				quo_x_s[k] <= {qx[k][QBITS-2:0], st_x[k].qb};
				quo_y_s[k] <= {qy[k][QBITS-2:0], st_y[k].qb};
			end
			for (int k = 0; k < QBITS - 1; k++) begin
				rem_x_s[k] <= st_x[k].rem;
				rem_y_s[k] <= st_y[k].rem;
				nlo_x_s[k] <= {lo_x[k][LO_W-2:0], 1'b0};
				nlo_y_s[k] <= {lo_y[k][LO_W-2:0], 1'b0};
				dv_s[k]    <= dv[k];
			end
		end
	end

	assign out_vld  = vld_s[QBITS-1];
	assign out_side = side_s[QBITS-1];
	assign quo_x    = quo_x_s[QBITS-1];
	assign quo_y    = quo_y_s[QBITS-1];

endmodule
